// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the divider, datapath and controller files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

// ----- rtl/nwrc_pkg.sv -----
// ----------------------------------------------------------------------------
// nwrc_pkg
// Types, widths and codes shared by the nearest wall ray cast modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nwrc_pkg;

	localparam int CoordBits   = 16;
	localparam int DeltaBits   = CoordBits + 1;
	localparam int MaxWallsDef = 256;

	// Shared signed multiplier, A by B.
	localparam int MulABits = 36;
	localparam int MulBBits = 18;
	localparam int MulPBits = MulABits + MulBBits;

	// Cross products and the squared distance.
	localparam int CrossBits = 36;
	localparam int SqBits    = 34;
	localparam int DistBits  = SqBits / 2;
	localparam int StepBits  = 18;

	// Shared divider.
	localparam int DivNumBits = 54;
	localparam int DivDenBits = 36;
	localparam int DivQBits   = 19;

	// Register file.
	localparam int AddrBits = 4;
	localparam logic [1:0] RegWallCount   = 2'd0;
	localparam logic [1:0] RegHeightScale = 2'd1;
	localparam logic [1:0] RegProjConst   = 2'd2;

	localparam logic [8:0]  WallCountRst   = 9'd0;
	localparam logic [9:0]  HeightScaleRst = 10'd100;
	localparam logic [23:0] ProjConstRst   = 24'd61440;

	// Result status codes.
	localparam logic [1:0] StNoHit  = 2'd0;
	localparam logic [1:0] StHit    = 2'd1;
	localparam logic [1:0] StZero   = 2'd2;

	localparam logic       OpLoad   = 1'b0;
	localparam logic       OpCast   = 1'b1;

	localparam logic [7:0] LightMax   = 8'd255;
	localparam int         LightLimit = 2040;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_READ,
		OP_DELTA,
		OP_M_RSY,
		OP_M_RYSX,
		OP_RS,
		OP_M_QYRX,
		OP_QPR,
		OP_M_QYSX,
		OP_QPS,
		OP_NORM,
		OP_M_NX,
		OP_DIVX,
		OP_PX,
		OP_M_NY,
		OP_DIVY,
		OP_PY,
		OP_M_DX,
		OP_M_DY,
		OP_SQ,
		OP_KEEP,
		OP_SQRT,
		OP_M_HP,
		OP_DIVH,
		OP_OUT
	} nwrc_op_t;

	typedef struct packed {
		logic      accept;
		nwrc_op_t  op;
	} nwrc_cmd_t;

	typedef struct packed {
		logic rs_zero;
		logic hit_ok;
		logic idx_end;
		logic div_busy;
		logic sqrt_busy;
		logic found;
		logic best_zero;
	} nwrc_sts_t;

endpackage

`default_nettype wire

// ----- rtl/nwrc_div.sv -----
// ----------------------------------------------------------------------------
// nwrc_div
// Restoring divider, one quotient bit per cycle; the quotient must fit Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nwrc_div import nwrc_pkg::*; #(
	parameter int NUM_W = DivNumBits,
	parameter int DEN_W = DivDenBits,
	parameter int Q_W   = DivQBits
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [Q_W-1:0]        quot,
	output logic                  rem_nz
);

	localparam int CW = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> Q_W);
			quo_q <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign busy   = busy_q;
	assign quot   = quo_q;
	assign rem_nz = |rem_q;

	`ASSERT_ALWAYS(a_busy_cnt, clk, arst_n, busy_q == (cnt_q != '0))

endmodule

`default_nettype wire

// ----- rtl/nwrc_sqrt.sv -----
// ----------------------------------------------------------------------------
// nwrc_sqrt
// Integer square root, one root bit per cycle, result rounded down.
// ----------------------------------------------------------------------------
`default_nettype none

module nwrc_sqrt import nwrc_pkg::*; #(
	parameter int IN_W = SqBits
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [IN_W-1:0] radicand,
	output logic                 busy,
	output logic [IN_W/2-1:0]    root
);

	localparam int OW = IN_W / 2;
	localparam int RW = OW + 2;
	localparam int CW = $clog2(OW + 1);

	logic [IN_W-1:0] rad_q;
	logic [RW-1:0]   rem_q;
	logic [OW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [RW+1:0]   nxt;
	logic [RW+1:0]   trial;
	logic            ge;

	assign nxt   = {rem_q, rad_q[IN_W-1:IN_W-2]};
	assign trial = (RW + 2)'({root_q, 2'b01});
	assign ge    = nxt >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(OW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? RW'(nxt - trial) : RW'(nxt);
			root_q <= {root_q[OW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ----- rtl/nwrc_dp.sv -----
// ----------------------------------------------------------------------------
// nwrc_dp
// Datapath: wall memory, shared multiplier, divider, square root, result regs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nwrc_dp import nwrc_pkg::*; #(
	parameter int MAX_WALLS = MaxWallsDef
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire nwrc_cmd_t                   cmd,
	output nwrc_sts_t                        sts,
	input  wire logic                        operation,
	input  wire logic [7:0]                  wall_index,
	input  wire logic signed [CoordBits-1:0] first_x,
	input  wire logic signed [CoordBits-1:0] first_y,
	input  wire logic signed [CoordBits-1:0] second_x,
	input  wire logic signed [CoordBits-1:0] second_y,
	input  wire logic [8:0]                  wall_count,
	input  wire logic [9:0]                  wall_height_scale,
	input  wire logic [23:0]                 projection_constant,
	output logic [1:0]                       status,
	output logic signed [CoordBits-1:0]      hit_x,
	output logic signed [CoordBits-1:0]      hit_y,
	output logic [15:0]                      distance,
	output logic [15:0]                      wall_height,
	output logic [7:0]                       lightness
);

	localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int CW = $clog2(MAX_WALLS + 1);
	localparam int EW = 4 * CoordBits;

	logic [EW-1:0] mem [MAX_WALLS];
	logic [EW-1:0] mem_q;

	logic [CW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic          found_q;

	logic signed [CoordBits-1:0] ax_q, ay_q, hx_q, hy_q;
	logic signed [DeltaBits-1:0] rx_q, ry_q, sx_q, sy_q, qx_q, qy_q;
	logic signed [CrossBits-1:0] rs_q, qpr_q, qps_q;
	logic signed [MulPBits-1:0]  mul_q, t1_q;
	logic signed [StepBits-1:0]  dx_q, dy_q;
	logic [SqBits-1:0]           sq_q, best_q;
	logic                        neg_q;
	logic                        h_sat_q;

	logic signed [MulABits-1:0]  mul_a;
	logic signed [MulBBits-1:0]  mul_b;
	logic                        mul_en;

	logic signed [CoordBits-1:0] w_x1, w_y1, w_x2, w_y2;

	logic signed [MulPBits+1:0]  rnd_a;
	logic [MulPBits+1:0]         rnd_mag;
	logic                        div_start;
	logic [DivNumBits-1:0]       div_num;
	logic [DivDenBits-1:0]       div_den;
	logic                        div_busy;
	logic [DivQBits-1:0]         div_quot;
	logic                        div_rem_nz;
	logic signed [DivQBits+1:0]  step_val;

	logic                        sqrt_busy;
	logic [DistBits-1:0]         root_d;
	logic [DivDenBits-1:0]       den_h;
	logic [MulPBits-1:0]         sat_lim;

	assign w_x1 = mem_q[4*CoordBits-1:3*CoordBits];
	assign w_y1 = mem_q[3*CoordBits-1:2*CoordBits];
	assign w_x2 = mem_q[2*CoordBits-1:CoordBits];
	assign w_y2 = mem_q[CoordBits-1:0];

	// Wall table.
	always_ff @(posedge clk) begin
		if (cmd.accept && operation == OpLoad && {24'd0, wall_index} < MAX_WALLS) begin
			mem[AW'(wall_index)] <= {first_x, first_y, second_x, second_y};
		end
		if (cmd.op == OP_READ) begin
			mem_q <= mem[idx_q[AW-1:0]];
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op)
			OP_M_RSY:  begin mul_a = MulABits'(rx_q); mul_b = MulBBits'(sy_q); end
			OP_M_RYSX: begin mul_a = MulABits'(ry_q); mul_b = MulBBits'(sx_q); end
			OP_RS:     begin mul_a = MulABits'(qx_q); mul_b = MulBBits'(ry_q); end
			OP_M_QYRX: begin mul_a = MulABits'(qy_q); mul_b = MulBBits'(rx_q); end
			OP_QPR:    begin mul_a = MulABits'(qx_q); mul_b = MulBBits'(sy_q); end
			OP_M_QYSX: begin mul_a = MulABits'(qy_q); mul_b = MulBBits'(sx_q); end
			OP_M_NX:   begin mul_a = MulABits'(qps_q); mul_b = MulBBits'(rx_q); end
			OP_M_NY:   begin mul_a = MulABits'(qps_q); mul_b = MulBBits'(ry_q); end
			OP_M_DX:   begin mul_a = MulABits'(dx_q); mul_b = dx_q; end
			OP_M_DY:   begin mul_a = MulABits'(dy_q); mul_b = dy_q; end
			OP_M_HP: begin
				mul_a = signed'({12'd0, projection_constant});
				mul_b = signed'({8'd0, wall_height_scale});
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= mul_a * mul_b;
		end
	end

	// Rounded quotient: floor((2n + d) / 2d) with d = rs.
	assign rnd_a   = (signed'((MulPBits + 2)'(mul_q)) <<< 1) + (MulPBits + 2)'(rs_q);
	assign rnd_mag = rnd_a[MulPBits+1] ? $unsigned(-rnd_a) : $unsigned(rnd_a);
	assign step_val = neg_q
		? -($signed({2'b00, div_quot}) + $signed({{(DivQBits+1){1'b0}}, div_rem_nz}))
		: $signed({2'b00, div_quot});

	assign den_h   = DivDenBits'({root_d, 4'd0});
	assign sat_lim = MulPBits'(den_h) << 16;

	always_comb begin
		div_start = 1'b0;
		div_num   = DivNumBits'(rnd_mag);
		div_den   = DivDenBits'(rs_q) << 1;
		case (cmd.op)
			OP_DIVX, OP_DIVY: div_start = 1'b1;
			OP_DIVH: begin
				div_start = 1'b1;
				div_num   = DivNumBits'($unsigned(mul_q));
				div_den   = den_h;
			end
			default: div_start = 1'b0;
		endcase
	end

	nwrc_div #(
		.NUM_W (DivNumBits),
		.DEN_W (DivDenBits),
		.Q_W   (DivQBits)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot),
		.rem_nz (div_rem_nz)
	);

	nwrc_sqrt #(
		.IN_W (SqBits)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT),
		.radicand (best_q),
		.busy     (sqrt_busy),
		.root     (root_d)
	);

	// Loop control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			n_q     <= '0;
			found_q <= 1'b0;
		end else if (cmd.accept && operation == OpCast) begin
			idx_q   <= '0;
			n_q     <= (32'(wall_count) > MAX_WALLS) ? CW'(MAX_WALLS) : CW'(wall_count);
			found_q <= 1'b0;
		end else begin
			if (cmd.op == OP_READ) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.op == OP_KEEP && (!found_q || sq_q < best_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	// Arithmetic registers.
	always_ff @(posedge clk) begin
		if (cmd.accept && operation == OpCast) begin
			ax_q <= first_x;
			ay_q <= first_y;
			rx_q <= DeltaBits'(second_x) - DeltaBits'(first_x);
			ry_q <= DeltaBits'(second_y) - DeltaBits'(first_y);
		end
		case (cmd.op)
			OP_DELTA: begin
				sx_q <= DeltaBits'(w_x2) - DeltaBits'(w_x1);
				sy_q <= DeltaBits'(w_y2) - DeltaBits'(w_y1);
				qx_q <= DeltaBits'(w_x1) - DeltaBits'(ax_q);
				qy_q <= DeltaBits'(w_y1) - DeltaBits'(ay_q);
			end
			OP_M_RYSX, OP_M_QYRX, OP_M_QYSX, OP_M_DY: t1_q <= mul_q;
			OP_RS:  rs_q  <= CrossBits'(t1_q - mul_q);
			OP_QPR: qpr_q <= CrossBits'(t1_q - mul_q);
			OP_QPS: qps_q <= CrossBits'(t1_q - mul_q);
			OP_NORM: begin
				if (rs_q < 0) begin
					rs_q  <= -rs_q;
					qpr_q <= -qpr_q;
					qps_q <= -qps_q;
				end
			end
			OP_DIVX, OP_DIVY: neg_q <= rnd_a[MulPBits+1];
			OP_PX: dx_q <= StepBits'(step_val);
			OP_PY: dy_q <= StepBits'(step_val);
			OP_SQ: sq_q <= SqBits'(t1_q + mul_q);
			OP_KEEP: begin
				if (!found_q || sq_q < best_q) begin
					best_q <= sq_q;
					hx_q   <= ax_q + CoordBits'(dx_q);
					hy_q   <= ay_q + CoordBits'(dy_q);
				end
			end
			OP_DIVH: h_sat_q <= $unsigned(mul_q) >= sat_lim;
			default: ;
		endcase
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			if (!found_q) begin
				status      <= StNoHit;
				hit_x       <= '0;
				hit_y       <= '0;
				distance    <= '0;
				wall_height <= '0;
				lightness   <= '0;
			end else if (best_q == '0) begin
				status      <= StZero;
				hit_x       <= hx_q;
				hit_y       <= hy_q;
				distance    <= '0;
				wall_height <= 16'hFFFF;
				lightness   <= LightMax;
			end else begin
				status      <= StHit;
				hit_x       <= hx_q;
				hit_y       <= hy_q;
				distance    <= (root_d > DistBits'(16'hFFFF)) ? 16'hFFFF : 16'(root_d);
				wall_height <= h_sat_q ? 16'hFFFF : div_quot[15:0];
				lightness   <= (32'(root_d) >= LightLimit) ? 8'd0
					: LightMax - 8'((root_d + DistBits'(7)) >> 3);
			end
		end
	end

	assign sts.rs_zero   = rs_q == '0;
	assign sts.hit_ok    = qpr_q >= 0 && qpr_q <= rs_q && qps_q >= 0 && qps_q <= rs_q;
	assign sts.idx_end   = idx_q == n_q;
	assign sts.div_busy  = div_busy;
	assign sts.sqrt_busy = sqrt_busy;
	assign sts.found     = found_q;
	assign sts.best_zero = best_q == '0;

	`ASSERT_ALWAYS(a_idx_bound, clk, arst_n, idx_q <= n_q)

endmodule

`default_nettype wire

// ----- rtl/nwrc_ctrl.sv -----
// ----------------------------------------------------------------------------
// nwrc_ctrl
// Sequencer: walks the wall loop and the finishing steps, owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nwrc_ctrl import nwrc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire logic      operation,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire nwrc_sts_t sts,
	output nwrc_cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_LOOP, S_READ, S_DELTA, S_M1, S_M2, S_RS, S_M4, S_QPR, S_M6,
		S_QPS, S_NORM, S_TEST, S_MNX, S_DIVX, S_WX, S_PX, S_MNY, S_DIVY, S_WY,
		S_PY, S_MDX, S_MDY, S_SQ, S_KEEP, S_FIN, S_SQRT, S_WSQ, S_MHP, S_DIVH,
		S_WH, S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept = in_valid && state_q == S_IDLE;
		unique case (state_q)
			S_READ:  cmd.op = OP_READ;
			S_DELTA: cmd.op = OP_DELTA;
			S_M1:    cmd.op = OP_M_RSY;
			S_M2:    cmd.op = OP_M_RYSX;
			S_RS:    cmd.op = OP_RS;
			S_M4:    cmd.op = OP_M_QYRX;
			S_QPR:   cmd.op = OP_QPR;
			S_M6:    cmd.op = OP_M_QYSX;
			S_QPS:   cmd.op = OP_QPS;
			S_NORM:  cmd.op = OP_NORM;
			S_MNX:   cmd.op = OP_M_NX;
			S_DIVX:  cmd.op = OP_DIVX;
			S_PX:    cmd.op = OP_PX;
			S_MNY:   cmd.op = OP_M_NY;
			S_DIVY:  cmd.op = OP_DIVY;
			S_PY:    cmd.op = OP_PY;
			S_MDX:   cmd.op = OP_M_DX;
			S_MDY:   cmd.op = OP_M_DY;
			S_SQ:    cmd.op = OP_SQ;
			S_KEEP:  cmd.op = OP_KEEP;
			S_SQRT:  cmd.op = OP_SQRT;
			S_MHP:   cmd.op = OP_M_HP;
			S_DIVH:  cmd.op = OP_DIVH;
			S_OUT:   cmd.op = slot_free ? OP_OUT : OP_NOP;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (in_valid && operation == OpCast) state_q <= S_LOOP;
				S_LOOP:  state_q <= sts.idx_end ? S_FIN : S_READ;
				S_READ:  state_q <= S_DELTA;
				S_DELTA: state_q <= S_M1;
				S_M1:    state_q <= S_M2;
				S_M2:    state_q <= S_RS;
				S_RS:    state_q <= S_M4;
				S_M4:    state_q <= S_QPR;
				S_QPR:   state_q <= S_M6;
				S_M6:    state_q <= S_QPS;
				S_QPS:   state_q <= S_NORM;
				S_NORM:  state_q <= sts.rs_zero ? S_LOOP : S_TEST;
				S_TEST:  state_q <= sts.hit_ok ? S_MNX : S_LOOP;
				S_MNX:   state_q <= S_DIVX;
				S_DIVX:  state_q <= S_WX;
				S_WX:    if (!sts.div_busy) state_q <= S_PX;
				S_PX:    state_q <= S_MNY;
				S_MNY:   state_q <= S_DIVY;
				S_DIVY:  state_q <= S_WY;
				S_WY:    if (!sts.div_busy) state_q <= S_PY;
				S_PY:    state_q <= S_MDX;
				S_MDX:   state_q <= S_MDY;
				S_MDY:   state_q <= S_SQ;
				S_SQ:    state_q <= S_KEEP;
				S_KEEP:  state_q <= S_LOOP;
				S_FIN:   state_q <= (!sts.found || sts.best_zero) ? S_OUT : S_SQRT;
				S_SQRT:  state_q <= S_WSQ;
				S_WSQ:   if (!sts.sqrt_busy) state_q <= S_MHP;
				S_MHP:   state_q <= S_DIVH;
				S_DIVH:  state_q <= S_WH;
				S_WH:    if (!sts.div_busy) state_q <= S_OUT;
				S_OUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_idle_units, clk, arst_n, state_q == S_IDLE, !sts.div_busy && !sts.sqrt_busy)
	`ASSERT_IMPLIES(a_out_drop, clk, arst_n, $fell(out_valid_q), $past(!out_stall))

endmodule

`default_nettype wire

// ----- rtl/nearest_wall_ray_cast_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_wall_ray_cast_unit
// Nearest wall hit of a ray against a loaded table of wall segments.
// ----------------------------------------------------------------------------
// Usage. Input transactions on in_valid/in_stall either load one wall entry
// (operation 0, no result) or cast a ray (operation 1). A cast tests
// entries 0 .. min(wall_count, MAX_WALLS)-1 in order with a shared
// multiplier and a 19-step divider; it yields exactly one result transaction
// on out_valid/out_stall with the nearest hit point, its distance, the
// projected wall height and a lightness shade.
// Walls are tested one at a time: a parallel wall ends after the cross
// products, a wall that misses ends after the hit test, and a wall that is
// hit takes two divider passes. A hit at nonzero distance adds a 17-step
// square root and one more divider pass at the end. The wall loop runs on
// the single multiplier and divider; only one cast is in flight at a time and
// in_stall stays high while it runs.
// The result sits in an output register: once written, the block accepts the
// next transaction even while out_stall holds that result. A new result waits
// in its final step only when the previous one has still not been taken.
// Reset clears the controller and the registers below to their defaults; the
// wall table itself holds nothing useful until loaded.
// Registers (APB, 32-bit): 0x0 wall_count, 0x4 wall_height_scale,
// 0x8 projection_constant. Write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_wall_ray_cast_unit import nwrc_pkg::*; #(
	parameter int MAX_WALLS = MaxWallsDef
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Input channel.
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        operation,
	input  wire logic [7:0]                  wall_index,
	input  wire logic signed [CoordBits-1:0] first_x,
	input  wire logic signed [CoordBits-1:0] first_y,
	input  wire logic signed [CoordBits-1:0] second_x,
	input  wire logic signed [CoordBits-1:0] second_y,
	// Result channel.
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       status,
	output logic signed [CoordBits-1:0]      hit_x,
	output logic signed [CoordBits-1:0]      hit_y,
	output logic [15:0]                      distance,
	output logic [15:0]                      wall_height,
	output logic [7:0]                       lightness,
	// Configuration port.
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [AddrBits-1:0]         paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic [8:0]  wall_count_q;
	logic [9:0]  height_scale_q;
	logic [23:0] proj_const_q;
	logic [1:0]  reg_sel;
	nwrc_cmd_t   cmd;
	nwrc_sts_t   sts;

	// Registers sit on word boundaries; the low address bits are ignored.
	assign reg_sel = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_count_q   <= WallCountRst;
			height_scale_q <= HeightScaleRst;
			proj_const_q   <= ProjConstRst;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				RegWallCount:   wall_count_q   <= pwdata[8:0];
				RegHeightScale: height_scale_q <= pwdata[9:0];
				RegProjConst:   proj_const_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			RegWallCount:   prdata = 32'(wall_count_q);
			RegHeightScale: prdata = 32'(height_scale_q);
			RegProjConst:   prdata = 32'(proj_const_q);
			default:        prdata = '0;
		endcase
	end

	nwrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	nwrc_dp #(
		.MAX_WALLS (MAX_WALLS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.operation           (operation),
		.wall_index          (wall_index),
		.first_x             (first_x),
		.first_y             (first_y),
		.second_x            (second_x),
		.second_y            (second_y),
		.wall_count          (wall_count_q),
		.wall_height_scale   (height_scale_q),
		.projection_constant (proj_const_q),
		.status              (status),
		.hit_x               (hit_x),
		.hit_y               (hit_y),
		.distance            (distance),
		.wall_height         (wall_height),
		.lightness           (lightness)
	);

endmodule

`default_nettype wire
